// ----- sv/wum_pkg.sv -----
// shared types and constants for the wildcard url matcher
// no dependencies
`default_nettype none

package wum_pkg;

    localparam int PATTERN_MAX_DEF = 64;
    localparam logic [7:0] WILDCARD = 8'd42;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_URL    = 2'd2,
        REQ_END    = 2'd3
    } req_type_t;

    // broadcast control for one pattern cell
    typedef struct packed {
        logic       feed;
        logic       rearm;
        logic       rearm_live;
        logic       act;
        logic       wr;
        logic [7:0] data;
    } cell_ctrl_t;

    // hand-off from one cell to the next position
    typedef struct packed {
        logic adv;
        logic clos;
    } cell_link_t;

endpackage

`default_nettype wire

// ----- sv/wum_req_if.sv -----
// request channel: req_type and data_byte with valid/ready
// no dependencies
`default_nettype none

interface wum_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/wum_res_if.sv -----
// result channel: matched and pattern_overflow with valid/ready
// no dependencies
`default_nettype none

interface wum_res_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

// ----- sv/wildcard_url_matcher_top.sv -----
// top level of the wildcard url matcher: pattern bookkeeping and the cell row
// depends on wum_pkg, wum_req_if, wum_res_if, wum_cell
//
//   channel  dir  fields                        handshake
//   req      in   req_type, data_byte           valid/ready
//   res      out  matched, pattern_overflow     valid/ready
//
// one item per cycle while req.ready is high; a url byte updates every pattern position at once in the cell row
// an end-of-url item shows its result in the cycle after acceptance in the output register
// runs of stars are stored as one star, so star closure reaches only the next cell
// reset leaves an empty pattern with position zero live; no clearing pass
// req.ready drops only while a result is held and res.ready is low
`default_nettype none

module wildcard_url_matcher_top
    import wum_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    wum_req_if.sink   req,
    wum_res_if.source res
);

    localparam int CW = $clog2(PATTERN_MAX + 1);
    localparam logic [CW-1:0] LEN_FULL = CW'(PATTERN_MAX);

    logic [CW-1:0] clen_reg, clen_next;
    logic [CW-1:0] llen_reg, llen_next;
    logic          ovf_reg, ovf_next;
    logic          last_star_reg, last_star_next;
    logic          first_star_reg, first_star_next;
    logic          res_valid_reg, res_valid_next;
    logic          matched_reg, matched_next;
    logic          povf_reg, povf_next;

    logic          accept;
    logic          is_star_in;
    logic          app_store;
    logic          do_rearm;
    logic          do_feed;
    req_type_t     op;

    cell_ctrl_t               ctrl [PATTERN_MAX+1];
    cell_link_t               link [PATTERN_MAX+2];
    logic [PATTERN_MAX:0]     live;

    assign op         = req_type_t'(req.req_type);
    assign req.ready  = !res_valid_reg || res.ready;
    assign accept     = req.valid && req.ready;
    assign is_star_in = (req.data_byte == WILDCARD);

    always_comb
    begin
        clen_next       = clen_reg;
        llen_next       = llen_reg;
        ovf_next        = ovf_reg;
        last_star_next  = last_star_reg;
        first_star_next = first_star_reg;
        app_store       = 1'b0;
        do_rearm        = 1'b0;
        do_feed         = 1'b0;
        matched_next    = matched_reg;
        povf_next       = povf_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        if (accept)
        begin
            unique case (op)
                REQ_CLEAR:
                begin
                    clen_next       = '0;
                    llen_next       = '0;
                    ovf_next        = 1'b0;
                    last_star_next  = 1'b0;
                    first_star_next = 1'b0;
                    do_rearm        = 1'b1;
                end
                REQ_APPEND:
                begin
                    do_rearm = 1'b1;
                    if (llen_reg < LEN_FULL)
                    begin
                        llen_next = llen_reg + CW'(1);
                        if (!(is_star_in && last_star_reg))
                        begin
                            app_store      = 1'b1;
                            clen_next      = clen_reg + CW'(1);
                            last_star_next = is_star_in;
                            if (clen_reg == '0)
                            begin
                                first_star_next = is_star_in;
                            end
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                REQ_URL:
                begin
                    do_feed = 1'b1;
                end
                REQ_END:
                begin
                    do_rearm       = 1'b1;
                    res_valid_next = 1'b1;
                    matched_next   = live[clen_reg];
                    povf_next      = ovf_reg;
                end
                default:
                begin
                    do_feed = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clen_reg       <= '0;
            llen_reg       <= '0;
            ovf_reg        <= 1'b0;
            last_star_reg  <= 1'b0;
            first_star_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            clen_reg       <= clen_next;
            llen_reg       <= llen_next;
            ovf_reg        <= ovf_next;
            last_star_reg  <= last_star_next;
            first_star_reg <= first_star_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        povf_reg    <= povf_next;
    end

    assign link[0] = '0;

    for (genvar i = 0; i <= PATTERN_MAX; i++)
    begin : g_cell
        always_comb
        begin
            ctrl[i].feed  = do_feed;
            ctrl[i].rearm = do_rearm;
            if (i == 0)
            begin
                ctrl[i].rearm_live = 1'b1;
            end
            else if (i == 1)
            begin
                ctrl[i].rearm_live = first_star_next;
            end
            else
            begin
                ctrl[i].rearm_live = 1'b0;
            end
            ctrl[i].act  = (CW'(i) < clen_reg);
            ctrl[i].wr   = accept && app_store && (CW'(i) == clen_reg);
            ctrl[i].data = req.data_byte;
        end

        wum_cell #(
            .RST_LIVE (i == 0)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl[i]),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .live     (live[i])
        );
    end

    assign res.valid            = res_valid_reg;
    assign res.matched          = matched_reg;
    assign res.pattern_overflow = povf_reg;

    a_clen_le_llen: assert property (@(posedge clk) disable iff (!rst_n)
        clen_reg <= llen_reg)
        else $error("stored length exceeds logical length");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (llen_reg == LEN_FULL))
        else $error("overflow flagged with room left");

    a_last_star: assert property (@(posedge clk) disable iff (!rst_n)
        (last_star_reg || first_star_reg) |-> (clen_reg != '0))
        else $error("star flag set on empty pattern");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == REQ_CLEAR) |=> (clen_reg == '0 && live[0] && !live[1]))
        else $error("clear did not re-arm");

    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(accept && op == REQ_END))
        else $error("result without end of url");

endmodule

`default_nettype wire

// ----- sv/wum_cell.sv -----
// one pattern position: stored byte and live bit, linked to its neighbors
// depends on wum_pkg
`default_nettype none

module wum_cell
    import wum_pkg::*;
#(
    parameter logic RST_LIVE = 1'b0
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire cell_link_t link_in,
    output cell_link_t      link_out,
    output logic            live
);

    logic [7:0] data_reg;
    logic       live_reg;
    logic       live_next;
    logic       star;
    logic       stay;
    logic       pre;

    always_comb
    begin
        star          = (data_reg == WILDCARD);
        stay          = live_reg && ctrl.act && star;
        link_out.adv  = live_reg && ctrl.act && !star && (data_reg == ctrl.data);
        pre           = stay || link_in.adv;
        link_out.clos = pre && ctrl.act && star;
        if (ctrl.rearm)
        begin
            live_next = ctrl.rearm_live;
        end
        else if (ctrl.feed)
        begin
            live_next = pre || link_in.clos;
        end
        else
        begin
            live_next = live_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= RST_LIVE;
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            data_reg <= ctrl.data;
        end
    end

    assign live = live_reg;

endmodule

`default_nettype wire
